// File: hdl/pwnu_pkg.sv
`default_nettype none

package pwnu_pkg;

  localparam int WORD_BITS   = 21;
  localparam int PHASE_W     = 2;
  localparam int ACCUM_W     = 3;
  localparam int EXT_BITS    = WORD_BITS + ACCUM_W;
  localparam int NIB_W       = 4;
  localparam int CNT_W       = 3;
  localparam int FS_W        = $clog2(WORD_BITS + 1);
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [CNT_W-1:0] NIBBLES_SHORT = CNT_W'(5);
  localparam logic [CNT_W-1:0] NIBBLES_LONG  = CNT_W'(6);
  localparam logic [PHASE_W-1:0] PHASE_LAST  = PHASE_W'(3);
  localparam logic [WORD_BITS-1:0] WORD_ONES = {WORD_BITS{1'b1}};

  typedef struct packed {
    logic [WORD_BITS-1:0] code_word;
    logic                 word_lost;
    logic                 msg_start;
    logic                 msg_end;
    logic                 initial_fragment;
    logic                 final_fragment;
  } in_t;

  typedef struct packed {
    logic [NIB_W-1:0] nibble;
    logic             nibble_valid;
    logic             nibble_unknown;
    logic             run_last;
    logic             message_end;
  } out_t;

  // One queued word: the bit stream it completes, how many nibbles to emit
  // and the flags that shape the results.
  typedef struct packed {
    logic [EXT_BITS-1:0] ext;
    logic [CNT_W-1:0]    cnt;
    logic                lost;
    logic                mend;
  } job_t;

endpackage

`default_nettype wire

// File: hdl/pwnu_front.sv
`default_nettype none

module pwnu_front (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire pwnu_pkg::in_t in_data,
  input  wire logic         q_full,
  output logic              push,
  output pwnu_pkg::job_t    push_job
);
  import pwnu_pkg::*;

  logic [PHASE_W-1:0]   phase_r, phase_nxt;
  logic [ACCUM_W-1:0]   accum_r, accum_nxt;
  logic                 seen_r, seen_nxt;

  logic [PHASE_W-1:0]   phase_eff;
  logic [ACCUM_W-1:0]   accum_eff;
  logic                 seen_eff;
  logic                 is_data;
  logic                 strip;
  logic [EXT_BITS-1:0]  ext;
  logic [CNT_W-1:0]     n_all;
  logic [WORD_BITS-1:0] diff;
  logic [FS_W-1:0]      fs;
  logic [FS_W-1:0]      keep_sum;
  logic [CNT_W-1:0]     keep;
  logic [CNT_W-1:0]     cnt;
  logic                 accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    // A fragment start wipes the carried state before the word is used.
    phase_eff = in_data.msg_start ? '0 : phase_r;
    accum_eff = in_data.msg_start ? '0 : accum_r;
    seen_eff  = in_data.msg_start ? 1'b0 : seen_r;
    is_data   = !(in_data.msg_start && in_data.initial_fragment);
    strip     = in_data.msg_end && in_data.final_fragment && !in_data.word_lost;

    ext   = ({{ACCUM_W{1'b0}}, in_data.code_word} << phase_eff) |
            {{WORD_BITS{1'b0}}, accum_eff};
    n_all = (phase_eff == PHASE_LAST) ? NIBBLES_LONG : NIBBLES_SHORT;

    // The fill run starts just above the highest bit that differs from bit 20.
    diff = in_data.code_word ^ {WORD_BITS{in_data.code_word[WORD_BITS-1]}};
    fs   = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      if (diff[b]) begin
        fs = FS_W'(b + 1);
      end
    end
    keep_sum = FS_W'(phase_eff) + fs + FS_W'(3);
    keep     = CNT_W'(keep_sum >> 2);

    if (!is_data) begin
      cnt = '0;
    end else if (strip) begin
      if (seen_eff && (in_data.code_word == '0 || in_data.code_word == WORD_ONES)) begin
        cnt = '0;
      end else if (fs != '0) begin
        cnt = (keep < n_all) ? keep : n_all;
      end else begin
        cnt = n_all;
      end
    end else begin
      cnt = n_all;
    end

    if (in_data.msg_end) begin
      phase_nxt = '0;
      accum_nxt = '0;
      seen_nxt  = 1'b0;
    end else if (is_data) begin
      phase_nxt = phase_eff + PHASE_W'(1);
      accum_nxt = (in_data.word_lost || phase_eff == PHASE_LAST) ?
                  '0 : ext[WORD_BITS-1 +: ACCUM_W];
      seen_nxt  = 1'b1;
    end else begin
      phase_nxt = phase_eff;
      accum_nxt = accum_eff;
      seen_nxt  = seen_eff;
    end
  end

  assign push          = accept && (cnt != '0 || in_data.msg_end);
  assign push_job.ext  = ext;
  assign push_job.cnt  = cnt;
  assign push_job.lost = in_data.word_lost;
  assign push_job.mend = in_data.msg_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      accum_r <= '0;
      seen_r  <= 1'b0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      accum_r <= accum_nxt;
      seen_r  <= seen_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hdl/pwnu_queue.sv
`default_nettype none

module pwnu_queue #(
  parameter int DEPTH = pwnu_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire pwnu_pkg::job_t push_job,
  input  wire logic          pop,
  output pwnu_pkg::job_t     head_job,
  output logic               empty,
  output logic               full
);
  import pwnu_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_QW = $clog2(DEPTH + 1);

  job_t              mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_QW-1:0] count_r;

  assign empty    = (count_r == '0);
  assign full     = (count_r == CNT_QW'(DEPTH));
  assign head_job = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_QW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_QW'(1);
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full) else $error("queue written while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty) else $error("queue read while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> count_r == $past(count_r) + CNT_QW'(1))
    else $error("queue occupancy lost a transfer");
`endif

endmodule

`default_nettype wire

// File: hdl/pwnu_back.sv
`default_nettype none

module pwnu_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire pwnu_pkg::job_t head_job,
  input  wire logic          q_empty,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output pwnu_pkg::out_t     out_data
);
  import pwnu_pkg::*;

  logic [CNT_W-1:0] idx_r;
  logic             out_valid_r;
  out_t             out_data_r;

  logic             load;
  logic             has_nib;
  logic [CNT_W-1:0] last_idx;
  logic             is_last;
  out_t             res;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    has_nib  = (head_job.cnt != '0);
    last_idx = has_nib ? head_job.cnt - CNT_W'(1) : '0;
    is_last  = (idx_r == last_idx);
    load     = !q_empty && (!out_valid_r || out_ready);

    // A job with no nibble is the bare end marker of its fragment.
    res.nibble         = (has_nib && !head_job.lost) ?
                         head_job.ext[{idx_r, 2'b00} +: NIB_W] : '0;
    res.nibble_valid   = has_nib;
    res.nibble_unknown = has_nib && head_job.lost;
    res.run_last       = is_last;
    res.message_end    = is_last && head_job.mend;
  end

  assign pop = load && is_last;

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        idx_r       <= is_last ? '0 : idx_r + CNT_W'(1);
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

`ifndef ASSERT_OFF
  a_unknown_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.nibble_unknown |->
      out_data_r.nibble == '0 && out_data_r.nibble_valid)
    else $error("unknown nibble carries a value");
  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.message_end |-> out_data_r.run_last)
    else $error("fragment end not on the last result of a word");
  a_job_held: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r != '0 |-> !q_empty && idx_r < head_job.cnt)
    else $error("nibble index left its job");
`endif

endmodule

`default_nettype wire

// File: hdl/pager_word_to_nibble_unpacker_core.sv
`default_nettype none

// Unpacks pager code words into a continuous LSB-first nibble stream. The
// front stage takes one word per cycle while the queue is not full, works out
// which nibbles the word completes and how many survive fill stripping, and
// pushes that as one job into a queue of QUEUE_DEPTH entries; the back stage
// emits the job's results one per cycle, while out_ready lets them drain,
// through an output register. The first result of a word is registered in the
// queue memory and then in the output register. A word occupies the back
// stage until it has emitted all its results (five or six for an ordinary
// data word, no more for a last word stripped of fill, one for a bare end
// marker), and a header word that is not the fragment's last yields nothing.
// Input is refused only while the queue is full.
module pager_word_to_nibble_unpacker_core #(
  parameter int QUEUE_DEPTH = pwnu_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire pwnu_pkg::in_t in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output pwnu_pkg::out_t     out_data
);
  import pwnu_pkg::*;

  logic push;
  logic pop;
  logic q_full;
  logic q_empty;
  job_t push_job;
  job_t head_job;

  pwnu_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  pwnu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .empty    (q_empty),
    .full     (q_full)
  );

  pwnu_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_job  (head_job),
    .q_empty   (q_empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
